// ===== hw/rtl/rda_pkg.sv =====
// shared types and constants for the reproducible double accumulator
package rda_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned BinBits = 52;
  localparam logic [10:0] ExpAllOnes = 11'h7FF;

  // special class codes, or-ed together as items arrive
  localparam logic [1:0] SpNone   = 2'd0;
  localparam logic [1:0] SpPosInf = 2'd1;
  localparam logic [1:0] SpNegInf = 2'd2;
  localparam logic [1:0] SpNan    = 2'd3;

  localparam logic [63:0] PosInfBits = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NegInfBits = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] QNanBits   = 64'h7FF8_0000_0000_0000;

  // classified item between front and back
  typedef struct packed {
    logic [1:0]         special;
    logic [5:0]         bin;
    logic signed [53:0] part_hi;
    logic signed [53:0] part_lo;
    logic               first;
    logic               last;
  } item_t;

  // accumulator snapshot handed to the rounder
  typedef struct packed {
    logic [1:0]   special;
    logic [5:0]   bin;
    logic [127:0] upper;
    logic [127:0] lower;
  } job_t;

endpackage

// ===== hw/rtl/rda_front.sv =====
// front part: splits a double into its bin index and two signed bin parts
module rda_front import rda_pkg::*; (
  input  logic [63:0] value_bits_i,
  input  logic        first_i,
  input  logic        last_i,
  output item_t       item_o
);

  logic [10:0] ex;
  logic        neg;
  logic [51:0] frac;
  logic [52:0] mant;
  logic [21:0] prod;
  logic [5:0]  q0, q, ni, shamt, lsh;
  logic [11:0] rem, span;
  logic [52:0] nu_mag;
  logic [63:0] lo_wide;
  logic [53:0] hi_mag, lo_mag;

  always_comb begin
    ex   = value_bits_i[62:52];
    neg  = value_bits_i[63];
    frac = value_bits_i[51:0];
    mant = (ex != 11'd0) ? {1'b1, frac} : 53'd0;

    // ex / 52 by reciprocal, undershoots by at most one
    prod = 22'(ex) * 22'd1260;
    q0   = prod[21:16];
    rem  = {1'b0, ex} - 12'(q0) * 12'(BinBits);
    q    = (rem >= 12'(BinBits)) ? q0 + 6'd1 : q0;
    ni   = q + 6'd1;

    span    = 12'(ni) * 12'(BinBits) - {1'b0, ex};
    shamt   = span[5:0];
    nu_mag  = mant >> shamt;
    lsh     = 6'(BinBits) - shamt;
    lo_wide = {11'd0, mant} << lsh;
    hi_mag  = {1'b0, nu_mag};
    lo_mag  = {2'b00, lo_wide[51:0]};

    item_o.bin     = ni;
    item_o.part_hi = neg ? (54'd0 - hi_mag) : hi_mag;
    item_o.part_lo = neg ? (54'd0 - lo_mag) : lo_mag;
    item_o.first   = first_i;
    item_o.last    = last_i;
    if (ex == ExpAllOnes) begin
      if (frac != 52'd0) begin
        item_o.special = SpNan;
      end else begin
        item_o.special = neg ? SpNegInf : SpPosInf;
      end
    end else begin
      item_o.special = SpNone;
    end
  end

endmodule

// ===== hw/rtl/rda_queue.sv =====
// short queue of classified items between front and back
module rda_queue import rda_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rda_back.sv =====
// back part: two-bin accumulator, one item per cycle; a last item waits until the rounder is ready
module rda_back import rda_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  job_valid_o,
  output job_t  job_o,
  input  logic  job_ready_i
);

  logic [5:0]   bin_q, bin_d, bi, ni, m;
  logic [127:0] upper_q, upper_d, lower_q, lower_d, su, sl, nu, nl;
  logic [1:0]   special_q, special_d, sp;

  assign pop_o       = valid_i & (~item_i.last | job_ready_i);
  assign job_valid_o = pop_o & item_i.last;

  always_comb begin
    bi = item_i.first ? 6'd0   : bin_q;
    su = item_i.first ? '0     : upper_q;
    sl = item_i.first ? '0     : lower_q;
    sp = item_i.first ? SpNone : special_q;
    ni = item_i.bin;
    nu = {{74{item_i.part_hi[53]}}, item_i.part_hi};
    nl = {{74{item_i.part_lo[53]}}, item_i.part_lo};
    m  = (ni > bi) ? ni : bi;

    if (item_i.special != SpNone) begin
      special_d = sp | item_i.special;
      bin_d     = bi;
      upper_d   = su;
      lower_d   = sl;
    end else begin
      special_d = sp;
      bin_d     = m;
      upper_d   = ((ni == m) ? nu : '0) + ((bi == m) ? su : '0);
      // a bin one below the new top moves into the lower sum
      lower_d   = ((ni == m) ? nl : '0)
                + (({1'b0, ni} + 7'd1 == {1'b0, m}) ? nu : '0)
                + ((bi == m) ? sl : '0)
                + (({1'b0, bi} + 7'd1 == {1'b0, m}) ? su : '0);
    end

    job_o.special = special_d;
    job_o.bin     = bin_d;
    job_o.upper   = upper_d;
    job_o.lower   = lower_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q     <= '0;
      upper_q   <= '0;
      lower_q   <= '0;
      special_q <= SpNone;
    end else if (pop_o) begin
      bin_q     <= bin_d;
      upper_q   <= upper_d;
      lower_q   <= lower_d;
      special_q <= special_d;
    end
  end

endmodule

// ===== hw/rtl/rda_round.sv =====
// rounder: combines the two bins, normalizes, rounds to double, holds the result
module rda_round import rda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_ready_o,
  output logic        empty_o,
  output logic [63:0] sum_bits_o,
  input  logic        pop_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSum  = 3'd1;
  localparam logic [2:0] StNeg  = 3'd2;
  localparam logic [2:0] StNorm = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [1:0]   special_q;
  logic [5:0]   bin_q;
  logic [127:0] upper_q, lower_q;
  logic [191:0] w_q;
  logic         sign_q, zero_q;
  logic [7:0]   left_q, limit_q, limit_n;
  logic [11:0]  limit_w;
  logic         out_valid_q, slot_free;
  logic [63:0]  out_q, res;

  logic [52:0]  mant, m53;
  logic [53:0]  mr;
  logic         rb, st, inc;
  logic [12:0]  biased, biased_r;

  assign job_ready_o = (state_q == StIdle);
  assign empty_o     = ~out_valid_q;
  assign sum_bits_o  = out_q;
  assign slot_free   = ~out_valid_q | pop_i;

  // left shift stops where the exponent reaches the subnormal floor
  assign limit_w = 12'd86 + 12'(bin_q) * 12'(BinBits);
  assign limit_n = (limit_w > 12'd191) ? 8'd191 : limit_w[7:0];

  always_comb begin
    mant     = w_q[191:139];
    rb       = w_q[138];
    st       = |w_q[137:0];
    inc      = rb & (st | mant[0]);
    mr       = {1'b0, mant} + 54'(inc);
    biased   = 13'd87 + 13'(bin_q) * 13'(BinBits) - 13'(left_q);
    m53      = mr[53] ? mr[53:1] : mr[52:0];
    biased_r = mr[53] ? biased + 13'd1 : biased;
    if (special_q == SpPosInf) begin
      res = PosInfBits;
    end else if (special_q == SpNegInf) begin
      res = NegInfBits;
    end else if (special_q == SpNan) begin
      res = QNanBits;
    end else if (zero_q) begin
      res = '0;
    end else if (m53[52]) begin
      if (biased_r >= 13'd2047) begin
        res = {sign_q, ExpAllOnes, 52'd0};
      end else begin
        res = {sign_q, biased_r[10:0], m53[51:0]};
      end
    end else begin
      res = {sign_q, 11'd0, m53[51:0]};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (job_valid_i) state_d = StSum;
      StSum:  state_d = (special_q != SpNone) ? StFin : StNeg;
      StNeg:  state_d = (w_q == '0) ? StFin : StNorm;
      StNorm: begin
        if (w_q[191] || left_q >= limit_q) begin
          state_d = StFin;
        end
      end
      StFin:  if (slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StFin && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          special_q <= job_i.special;
          bin_q     <= job_i.bin;
          upper_q   <= job_i.upper;
          lower_q   <= job_i.lower;
        end
      end
      StSum: begin
        w_q <= {{12{upper_q[127]}}, upper_q, 52'd0} + {{64{lower_q[127]}}, lower_q};
      end
      StNeg: begin
        sign_q  <= w_q[191];
        zero_q  <= (w_q == '0);
        w_q     <= w_q[191] ? (192'd0 - w_q) : w_q;
        left_q  <= '0;
        limit_q <= limit_n;
      end
      StNorm: begin
        if (!w_q[191] && left_q < limit_q) begin
          if (w_q[191:184] == 8'd0 && 9'(left_q) + 9'd8 <= 9'(limit_q)) begin
            w_q    <= w_q << 8;
            left_q <= left_q + 8'd8;
          end else begin
            w_q    <= w_q << 1;
            left_q <= left_q + 8'd1;
          end
        end
      end
      StFin: begin
        if (slot_free) begin
          out_q <= res;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/reproducible_double_accumulator_core.sv =====
// top level of the reproducible double accumulator
//
// input channel: an item (value_bits_i, first_i, last_i) is taken at a clock
// edge with push high and full low. first_i clears the sum before the value
// is added; last_i makes the block emit the rounded sum after adding it.
// result channel: while empty is low, sum_bits_o holds the oldest result; it
// is taken at an edge with pop high. one result per item that had last_i set.
// the front classifies an item in the cycle it is taken and writes it to a
// short queue; the back adds one item per cycle into the two-bin sums, so
// plain items stream at one per cycle.
// a last item hands the sums to the rounder, which sums the two bins, takes
// the magnitude and normalizes (8 bits or 1 bit per step) before the
// result reaches the output register; the back waits on a further last item
// while the rounder is busy, and the queue fills and raises full.
// when the receiver stalls, the result stays in the output register and the
// rounder holds its next result until that register is free.
// reset clears the sums and the queue, and marks the output register empty.
module reproducible_double_accumulator_core import rda_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] value_bits_i,
  input  logic        first_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] sum_bits_o
);

  item_t front_item, head_item;
  logic  head_valid, back_pop, job_valid, job_ready;
  job_t  job;

  rda_front u_front (
    .value_bits_i (value_bits_i),
    .first_i      (first_i),
    .last_i       (last_i),
    .item_o       (front_item)
  );

  rda_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (head_valid),
    .item_o  (head_item),
    .pop_i   (back_pop)
  );

  rda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .item_i      (head_item),
    .pop_o       (back_pop),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  rda_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .empty_o     (empty),
    .sum_bits_o  (sum_bits_o),
    .pop_i       (pop)
  );

endmodule
